### rtl/core/hc_pkg.sv
package hc_pkg;

    // alphabet and padding
    localparam logic [4:0] ALPHA      = 5'd26;
    localparam logic [4:0] PAD_LETTER = 5'd23;

    // register indexes on the write port
    localparam logic [2:0] REG_KEY_R0C0     = 3'd0;
    localparam logic [2:0] REG_KEY_R0C1     = 3'd1;
    localparam logic [2:0] REG_KEY_R1C0     = 3'd2;
    localparam logic [2:0] REG_KEY_R1C1     = 3'd3;
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd4;

    // cycles the key path needs to settle after reset or a register write
    localparam logic [2:0] SETTLE_CYCLES = 3'd5;

    // reciprocal of 26 scaled by 2^16, exact floor for values below 2048
    localparam logic [22:0] RECIP_26 = 23'd2521;

    // effective matrix and status handed to the datapath
    typedef struct packed {
        logic [4:0] m00;
        logic [4:0] m01;
        logic [4:0] m10;
        logic [4:0] m11;
        logic       key_error;
        logic       decrypt;
        logic       busy;
    } hc_key_t;

    // one letter pair on its way to the multiply stage
    typedef struct packed {
        logic [4:0] p0;
        logic [4:0] p1;
    } hc_pair_t;

    // value mod 26 for values below 2048
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [10:0] r;
        prod = 23'(x) * RECIP_26;
        q    = prod[22:16];
        r    = x - 11'(q) * 11'(ALPHA);
        return r[4:0];
    endfunction

    // 5-bit value mod 26
    function automatic logic [4:0] red26(input logic [4:0] v);
        return (v >= ALPHA) ? v - ALPHA : v;
    endfunction

    // additive inverse mod 26 of a reduced value
    function automatic logic [4:0] neg26(input logic [4:0] v);
        return (v == 5'd0) ? 5'd0 : ALPHA - v;
    endfunction

    // multiplicative inverse mod 26, bit 5 set when it exists
    function automatic logic [5:0] inv26(input logic [4:0] d);
        logic [5:0] res;
        case (d)
            5'd1:    res = {1'b1, 5'd1};
            5'd3:    res = {1'b1, 5'd9};
            5'd5:    res = {1'b1, 5'd21};
            5'd7:    res = {1'b1, 5'd15};
            5'd9:    res = {1'b1, 5'd3};
            5'd11:   res = {1'b1, 5'd19};
            5'd15:   res = {1'b1, 5'd7};
            5'd17:   res = {1'b1, 5'd23};
            5'd19:   res = {1'b1, 5'd11};
            5'd21:   res = {1'b1, 5'd5};
            5'd23:   res = {1'b1, 5'd17};
            5'd25:   res = {1'b1, 5'd25};
            default: res = {1'b0, 5'd0};
        endcase
        return res;
    endfunction

endpackage

### rtl/core/hill_cipher_2x2_stream.sv
// 2x2 hill cipher mod 26 on a letter stream (0 is a, 25 is z). letters pair up
// as row vectors and are multiplied by the key, or by its inverse in decrypt
// mode; each pair gives two output requests, first letter then second letter
// with last_of_pair set. an odd last letter is padded with x when encrypting
// and dropped when decrypting. a decrypt key whose determinant has no inverse
// mod 26 gives letter 0 with key_error set. letters and key entries 26..31 act
// as their value mod 26. one input request is taken per cycle while in_stall
// is low and output runs one letter per cycle while out_stall is low, so a
// full pair stream sustains one letter per cycle each way. the request that
// completes a pair reaches its first output letter through the pair, multiply
// and reduce registers. after reset and after every register write input
// stalls until the inverse-key pipeline has settled. registers are to be
// written by the user only while the block is idle; it does not enforce this
module hill_cipher_2x2_stream
    import hc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // register write port
    input  logic       cfg_write,
    input  logic [2:0] cfg_addr,
    input  logic [4:0] cfg_wdata,

    // input letters
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] letter_in,
    input  logic       end_of_text,

    // output letters
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] letter_out,
    output logic       last_of_pair,
    output logic       key_error
);

    hc_key_t  key;
    logic     pair_valid;
    logic     pair_ready;
    hc_pair_t pair;

    // key registers plus the effective matrix (key or its inverse)
    hc_key u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .key       (key)
    );

    // holds the first letter, forms pairs and pads or drops odd endings
    hc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .letter_in   (letter_in),
        .end_of_text (end_of_text),
        .key         (key),
        .pair_valid  (pair_valid),
        .pair        (pair),
        .pair_ready  (pair_ready)
    );

    // matrix multiply, mod 26 and the two-letter output register
    hc_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key),
        .pair_valid   (pair_valid),
        .pair         (pair),
        .pair_ready   (pair_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .letter_out   (letter_out),
        .last_of_pair (last_of_pair),
        .key_error    (key_error)
    );

endmodule

### rtl/core/hc_key.sv
module hc_key
    import hc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_addr,
    input  logic [4:0] cfg_wdata,
    output hc_key_t    key
);

    logic [4:0]  k00_reg, k01_reg, k10_reg, k11_reg;
    logic        decrypt_reg;
    logic [2:0]  settle_reg;
    logic [2:0]  settle_next;

    logic [9:0]  a_reg, b_reg;
    logic [4:0]  det_reg;
    logic [4:0]  inv_reg;
    logic        inv_ok_reg;
    logic [9:0]  t00_reg, t01_reg, t10_reg, t11_reg;
    logic [4:0]  e00_reg, e01_reg, e10_reg, e11_reg;
    logic        err_reg;
    logic [5:0]  inv_lookup;
    logic [10:0] det_sum;

    // register file, entries kept reduced mod 26
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k00_reg     <= 5'd1;
            k01_reg     <= 5'd0;
            k10_reg     <= 5'd0;
            k11_reg     <= 5'd1;
            decrypt_reg <= 1'b0;
            settle_reg  <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write)
            begin
                case (cfg_addr)
                    REG_KEY_R0C0:     k00_reg     <= red26(cfg_wdata);
                    REG_KEY_R0C1:     k01_reg     <= red26(cfg_wdata);
                    REG_KEY_R1C0:     k10_reg     <= red26(cfg_wdata);
                    REG_KEY_R1C1:     k11_reg     <= red26(cfg_wdata);
                    REG_DECRYPT_MODE: decrypt_reg <= cfg_wdata[0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cfg_write)
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != 3'd0)
            settle_next = settle_reg - 3'd1;
        else
            settle_next = settle_reg;
    end

    // det = k00*k11 - k01*k10 mod 26, offset by 650 to stay positive
    assign det_sum    = 11'(a_reg) + 11'd650 - 11'(b_reg);
    assign inv_lookup = inv26(det_reg);

    // inverse key pipeline, free running
    always_ff @(posedge clk)
    begin
        a_reg      <= 10'(k00_reg) * 10'(k11_reg);
        b_reg      <= 10'(k01_reg) * 10'(k10_reg);
        det_reg    <= mod26(det_sum);
        inv_reg    <= inv_lookup[4:0];
        inv_ok_reg <= inv_lookup[5];
        t00_reg    <= 10'(k11_reg) * 10'(inv_reg);
        t01_reg    <= 10'(neg26(k01_reg)) * 10'(inv_reg);
        t10_reg    <= 10'(neg26(k10_reg)) * 10'(inv_reg);
        t11_reg    <= 10'(k00_reg) * 10'(inv_reg);
        if (decrypt_reg)
        begin
            e00_reg <= mod26(11'(t00_reg));
            e01_reg <= mod26(11'(t01_reg));
            e10_reg <= mod26(11'(t10_reg));
            e11_reg <= mod26(11'(t11_reg));
        end
        else
        begin
            e00_reg <= k00_reg;
            e01_reg <= k01_reg;
            e10_reg <= k10_reg;
            e11_reg <= k11_reg;
        end
        err_reg <= decrypt_reg & ~inv_ok_reg;
    end

    assign key.m00       = e00_reg;
    assign key.m01       = e01_reg;
    assign key.m10       = e10_reg;
    assign key.m11       = e11_reg;
    assign key.key_error = err_reg;
    assign key.decrypt   = decrypt_reg;
    assign key.busy      = (settle_reg != 3'd0);

endmodule

### rtl/core/hc_front.sv
module hc_front
    import hc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] letter_in,
    input  logic       end_of_text,
    input  hc_key_t    key,
    output logic       pair_valid,
    output hc_pair_t   pair,
    input  logic       pair_ready
);

    logic       half_full_reg, half_full_next;
    logic [4:0] held_reg;
    logic       s1_valid_reg, s1_valid_next;
    hc_pair_t   s1_pair_reg;
    logic       s1_free;
    logic       accept;
    logic       make_pair;
    logic [4:0] letter_red;

    assign s1_free    = ~s1_valid_reg | pair_ready;
    // a request may form a pair unless it is a first letter in decrypt mode
    assign in_stall   = key.busy | (~s1_free & (half_full_reg | ~key.decrypt));
    assign accept     = in_valid & ~in_stall;
    assign letter_red = red26(letter_in);
    assign make_pair  = accept & (half_full_reg | (end_of_text & ~key.decrypt));

    always_comb
    begin
        half_full_next = half_full_reg;
        if (accept)
        begin
            if (half_full_reg)
                half_full_next = 1'b0;
            else if (!end_of_text)
                half_full_next = 1'b1;
        end
    end

    always_comb
    begin
        if (make_pair)
            s1_valid_next = 1'b1;
        else if (pair_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_full_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            half_full_reg <= half_full_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !half_full_reg && !end_of_text)
            held_reg <= letter_red;
        if (make_pair)
        begin
            if (half_full_reg)
            begin
                s1_pair_reg.p0 <= held_reg;
                s1_pair_reg.p1 <= letter_red;
            end
            else
            begin
                s1_pair_reg.p0 <= letter_red;
                s1_pair_reg.p1 <= PAD_LETTER;
            end
        end
    end

    assign pair_valid = s1_valid_reg;
    assign pair       = s1_pair_reg;

endmodule

### rtl/core/hc_mix.sv
module hc_mix
    import hc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hc_key_t    key,
    input  logic       pair_valid,
    input  hc_pair_t   pair,
    output logic       pair_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] letter_out,
    output logic       last_of_pair,
    output logic       key_error
);

    logic        s2_valid_reg, s2_valid_next;
    logic [10:0] x0_reg, x1_reg;
    logic        s2_err_reg;
    logic        out_valid_reg, out_valid_next;
    logic        phase_reg, phase_next;
    logic [4:0]  o0_reg, o1_reg;
    logic        err_reg;
    logic        out_ready;
    logic        out_take;
    logic        s2_load;
    logic        out_load;

    assign out_take   = out_valid_reg & ~out_stall;
    assign out_ready  = ~out_valid_reg | (phase_reg & ~out_stall);
    assign pair_ready = ~s2_valid_reg | out_ready;
    assign s2_load    = pair_valid & pair_ready;
    assign out_load   = s2_valid_reg & out_ready;

    always_comb
    begin
        if (s2_load)
            s2_valid_next = 1'b1;
        else if (out_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            phase_next     = 1'b0;
        end
        else if (out_take && phase_reg)
        begin
            out_valid_next = 1'b0;
            phase_next     = 1'b0;
        end
        else if (out_take)
            phase_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // row vector times matrix, reduced on the way to the output pair
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            x0_reg     <= 11'(10'(pair.p0) * 10'(key.m00)) + 11'(10'(pair.p1) * 10'(key.m10));
            x1_reg     <= 11'(10'(pair.p0) * 10'(key.m01)) + 11'(10'(pair.p1) * 10'(key.m11));
            s2_err_reg <= key.key_error;
        end
        if (out_load)
        begin
            o0_reg  <= s2_err_reg ? 5'd0 : mod26(x0_reg);
            o1_reg  <= s2_err_reg ? 5'd0 : mod26(x1_reg);
            err_reg <= s2_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign letter_out   = phase_reg ? o1_reg : o0_reg;
    assign last_of_pair = phase_reg;
    assign key_error    = err_reg;

endmodule

### rtl/core/hc_checker.sv
module hc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] letter_out,
    input logic       last_of_pair,
    input logic       key_error
);

    // a stalled output request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(letter_out)
            && $stable(last_of_pair) && $stable(key_error))
        else $error("stalled output request changed");

    // second letter follows right after the first, same error flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_pair |=> out_valid && last_of_pair
            && key_error == $past(key_error))
        else $error("pair second letter missing");

    // letters stay in the alphabet
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> letter_out < 5'd26)
        else $error("output letter out of range");

    // a bad key gives zero letters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_error |-> letter_out == 5'd0)
        else $error("nonzero letter with key error");

endmodule

bind hill_cipher_2x2_stream hc_checker u_hc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .letter_out   (letter_out),
    .last_of_pair (last_of_pair),
    .key_error    (key_error)
);
